FILE: rtl/softmax_gradient_row_core_defines.svh
// Assertion macros for the softmax gradient row core.
// Used by sgr_checker; expects clk and rst_n in scope.
`ifndef SOFTMAX_GRADIENT_ROW_CORE_DEFINES_SVH
`define SOFTMAX_GRADIENT_ROW_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SGR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sgr_pkg.sv
// Shared types, sizes and rounding helper for the softmax gradient row core.
// No dependencies.
package sgr_pkg;

    localparam int MAX_COLS    = 64;
    localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W       = $clog2(MAX_COLS + 1);
    localparam int ADDR_W      = COL_W + 1;
    localparam int RAM_DEPTH   = 2 ** ADDR_W;

    localparam int PROB_W      = 17;
    localparam int GRAD_W      = 32;
    localparam int ACC_W       = 48;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = PROB_W + 1 + GRAD_W;
    localparam int RND_W       = PROD_W - FRAC_W;
    localparam int SPLIT_W     = ACC_W / 2;
    localparam int LO_PROD_W   = PROB_W + SPLIT_W;
    localparam int HI_PROD_W   = PROB_W + 1 + SPLIT_W;
    localparam int FULL_W      = PROB_W + 1 + ACC_W;
    localparam int OUT_W       = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PROB_W-1:0]        prob;
        logic signed [GRAD_W-1:0] grad_in;
        logic                     last_in_row;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] grad_out;
        logic                    last_out;
        logic                    row_overflow;
    } out_word_t;

    typedef struct packed {
        logic [PROB_W-1:0]        prob;
        logic signed [GRAD_W-1:0] grad;
    } ram_word_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [CNT_W-1:0]        count;
        logic                    overflow;
        logic                    bank;
    } row_desc_t;

    // round a Q.32 product to Q.16, half up
    function automatic logic signed [RND_W-1:0] round_prod(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + PROD_W'(2 ** (FRAC_W - 1));
        return t[PROD_W-1:FRAC_W];
    endfunction

endpackage

FILE: rtl/softmax_gradient_row_core.sv
// Top level of the softmax gradient row core: front end, row queue, row RAM, back end.
// Depends on sgr_pkg, sgr_ram, sgr_row_fifo, sgr_front, sgr_back.
//
//  port group  | dir | word type  | meaning
//  ------------+-----+------------+--------------------------------------------
//  in_*        | in  | in_word_t  | one row element: prob, grad_in, last mark
//  out_*       | out | out_word_t | one gradient result per stored element
//
// The front end takes one word per cycle while fewer than two finished rows wait.
// The back end sends one result per cycle once a row is complete and out_ready is high.
// Its first result passes front s2, the row queue, and back s1, s2 and output registers.
// The row RAM holds two banks of MAX_COLS entries, so one row fills while another drains.
// A stall on out_ready freezes the back pipeline; the front keeps filling the free bank.
// Reset clears all control state; the RAM is not cleared.
module softmax_gradient_row_core
    import sgr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    ram_word_t         ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    ram_word_t         ram_rdata;
    logic              q_push;
    logic              q_pop;
    row_desc_t         q_desc;
    row_desc_t         q_head;
    logic [QCNT_W-1:0] q_count;

    sgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_desc    (q_desc)
    );

    sgr_row_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_desc),
        .pop       (q_pop),
        .head      (q_head),
        .count     (q_count)
    );

    sgr_ram #(
        .WIDTH ($bits(ram_word_t)),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sgr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_count   (q_count),
        .q_pop     (q_pop),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/sgr_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module sgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sgr_row_fifo.sv
// Short queue of finished row descriptors between front and back.
// Depends on sgr_pkg.
module sgr_row_fifo
    import sgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  row_desc_t         push_desc,
    input  logic              pop,
    output row_desc_t         head,
    output logic [QCNT_W-1:0] count
);

    row_desc_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

FILE: rtl/sgr_front.sv
// Front end: accepts input words, stores the row, accumulates the dot product.
// Depends on sgr_pkg; writes the row RAM and pushes row descriptors.
module sgr_front
    import sgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_word_t          in_data,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output ram_word_t         ram_wdata,
    input  logic [QCNT_W-1:0] q_count,
    output logic              q_push,
    output row_desc_t         q_desc
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic                    bank_reg, bank_next;
    logic                    s2_valid_reg, s2_store_reg, s2_last_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic [CNT_W-1:0]        s2_count_reg;
    logic                    s2_ovf_reg;
    logic                    s2_bank_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic [QCNT_W:0]         held;
    logic                    accept;
    logic                    store;
    logic signed [RND_W-1:0] rnd;
    logic signed [ACC_W-1:0] acc_sum;

    assign held     = {1'b0, q_count} + {{QCNT_W{1'b0}}, s2_valid_reg & s2_last_reg};
    assign in_ready = held < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept   = in_valid & in_ready;
    assign store    = count_reg < CNT_W'(MAX_COLS);

    assign ram_we         = accept & store;
    assign ram_waddr      = {bank_reg, count_reg[COL_W-1:0]};
    assign ram_wdata.prob = in_data.prob;
    assign ram_wdata.grad = in_data.grad_in;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (store)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (in_data.last_in_row)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                bank_next  = ~bank_reg;
            end
        end
    end

    assign rnd     = round_prod(s2_prod_reg);
    assign acc_sum = s2_store_reg ? acc_reg + {{(ACC_W - RND_W){rnd[RND_W-1]}}, rnd} : acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (s2_valid_reg)
        begin
            acc_next = s2_last_reg ? '0 : acc_sum;
        end
    end

    assign q_push         = s2_valid_reg & s2_last_reg;
    assign q_desc.dot      = acc_sum;
    assign q_desc.count    = s2_count_reg;
    assign q_desc.overflow = s2_ovf_reg;
    assign q_desc.bank     = s2_bank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            bank_reg     <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_store_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            bank_reg     <= bank_next;
            s2_valid_reg <= accept;
            s2_store_reg <= store;
            s2_last_reg  <= in_data.last_in_row;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_prod_reg  <= $signed({1'b0, in_data.prob}) * in_data.grad_in;
            s2_count_reg <= store ? count_reg + CNT_W'(1) : count_reg;
            s2_ovf_reg   <= ovf_reg | ~store;
            s2_bank_reg  <= bank_reg;
        end
    end

endmodule

FILE: rtl/sgr_back.sv
// Back end: reads stored rows and forms p * (g - dot), rounded and saturated.
// Depends on sgr_pkg; reads the row RAM and pops row descriptors.
module sgr_back
    import sgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  row_desc_t         head,
    input  logic [QCNT_W-1:0] q_count,
    output logic              q_pop,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  ram_word_t         ram_rdata,
    output logic              out_valid,
    input  logic              out_ready,
    output out_word_t         out_data
);

    logic [COL_W-1:0]            idx_reg, idx_next;
    logic                        s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic signed [ACC_W-1:0]     s1_dot_reg;
    logic                        s1_last_reg, s1_ovf_reg;
    logic [LO_PROD_W-1:0]        s2_lo_reg;
    logic signed [HI_PROD_W-1:0] s2_hi_reg;
    logic                        s2_last_reg, s2_ovf_reg;
    out_word_t                   out_data_reg;

    logic                        adv;
    logic                        issue;
    logic                        last_issue;
    logic signed [ACC_W-1:0]     diff;
    logic signed [FULL_W-1:0]    full;
    logic signed [FULL_W-FRAC_W-1:0] rnd;
    logic signed [OUT_W-1:0]     sat;

    assign adv        = ~out_valid_reg | out_ready;
    assign issue      = adv & (q_count != '0);
    assign last_issue = CNT_W'(idx_reg) == head.count - CNT_W'(1);
    assign q_pop      = issue & last_issue;
    assign ram_re     = issue;
    assign ram_raddr  = {head.bank, idx_reg};

    always_comb
    begin
        idx_next = idx_reg;
        if (issue)
        begin
            idx_next = last_issue ? '0 : idx_reg + COL_W'(1);
        end
    end

    assign diff = {{(ACC_W - GRAD_W){ram_rdata.grad[GRAD_W-1]}}, ram_rdata.grad} - s1_dot_reg;
    assign full = {s2_hi_reg, {SPLIT_W{1'b0}}}
                + {{(FULL_W - LO_PROD_W){1'b0}}, s2_lo_reg}
                + FULL_W'(2 ** (FRAC_W - 1));
    assign rnd  = full[FULL_W-1:FRAC_W];

    always_comb
    begin
        sat = rnd[OUT_W-1:0];
        if (!rnd[FULL_W-FRAC_W-1] && (|rnd[FULL_W-FRAC_W-2:OUT_W-1]))
        begin
            sat = {1'b0, {(OUT_W - 1){1'b1}}};
        end
        else if (rnd[FULL_W-FRAC_W-1] && !(&rnd[FULL_W-FRAC_W-2:OUT_W-1]))
        begin
            sat = {1'b1, {(OUT_W - 1){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dot_reg  <= head.dot;
            s1_last_reg <= last_issue;
            s1_ovf_reg  <= head.overflow;
            s2_lo_reg   <= ram_rdata.prob * diff[SPLIT_W-1:0];
            s2_hi_reg   <= $signed({1'b0, ram_rdata.prob}) * $signed(diff[ACC_W-1:SPLIT_W]);
            s2_last_reg <= s1_last_reg;
            s2_ovf_reg  <= s1_ovf_reg;
            out_data_reg.grad_out     <= sat;
            out_data_reg.last_out     <= s2_last_reg;
            out_data_reg.row_overflow <= s2_ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/sgr_checker.sv
// Port-level checker for softmax_gradient_row_core, bound to the top level.
// Depends on sgr_pkg and softmax_gradient_row_core_defines.svh.
`include "softmax_gradient_row_core_defines.svh"

module sgr_checker
    import sgr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    logic [CNT_W-1:0] run_cnt_reg, run_cnt_next;
    logic             ovf_reg, ovf_next;
    logic [2:0]       pending_reg, pending_next;
    logic             in_last;
    logic             out_take;
    logic             out_last;

    assign in_last  = in_valid & in_ready & in_data.last_in_row;
    assign out_take = out_valid & out_ready;
    assign out_last = out_take & out_data.last_out;

    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        ovf_next     = ovf_reg;
        if (out_take)
        begin
            run_cnt_next = out_data.last_out ? '0 : run_cnt_reg + CNT_W'(1);
            ovf_next     = out_data.row_overflow;
        end
        pending_next = pending_reg + {2'b00, in_last} - {2'b00, out_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
            pending_reg <= '0;
        end
        else
        begin
            run_cnt_reg <= run_cnt_next;
            ovf_reg     <= ovf_next;
            pending_reg <= pending_next;
        end
    end

    `SGR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
    `SGR_ASSERT_NOW(a_row_len, out_take && !out_data.last_out, run_cnt_reg < CNT_W'(MAX_COLS - 1), "row longer than capacity")
    `SGR_ASSERT_NOW(a_ovf_full, out_last && out_data.row_overflow, run_cnt_reg == CNT_W'(MAX_COLS - 1), "overflowed row not full")
    `SGR_ASSERT_NOW(a_ovf_steady, out_take && run_cnt_reg != '0, out_data.row_overflow == ovf_reg, "overflow flag changed within a row")
    `SGR_ASSERT_NOW(a_no_orphan, out_valid, pending_reg != '0, "result without a finished input row")

endmodule

bind softmax_gradient_row_core sgr_checker u_sgr_checker (.*);

FILE: bench/tb_softmax_gradient_row_core.sv
// Testbench for softmax_gradient_row_core: random rows against a built-in row predictor.
// Depends on sgr_pkg and the softmax_gradient_row_core RTL; valid/ready on both sides.
module tb_softmax_gradient_row_core;
    import sgr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 180;
    localparam int DRAIN_CYCLES = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    softmax_gradient_row_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    in_word_t  pending_words[$];
    out_word_t expected_grads[$];

    longint row_prob[MAX_COLS];
    longint row_grad[MAX_COLS];
    longint row_dot = 0;
    int     row_len = 0;
    bit     row_dropped = 1'b0;

    int  fail_count    = 0;
    int  cycle_count   = 0;
    int  in_taken      = 0;
    int  in_gap        = 0;
    int  out_hold      = 0;
    bit  pressure_done = 1'b0;
    bit  quiet         = 1'b0;

    always #6 clk = ~clk;

    function automatic longint round_half_up(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    // store the element, accumulate, and on the last mark emit the row's gradients
    function automatic void absorb_element(input in_word_t w);
        longint    p;
        longint    g;
        longint    r;
        out_word_t o;
        p = longint'(w.prob);
        g = longint'($signed(w.grad_in));
        if (row_len < MAX_COLS)
        begin
            row_prob[row_len] = p;
            row_grad[row_len] = g;
            row_dot += round_half_up(p * g);
            row_len++;
        end
        else
            row_dropped = 1'b1;
        if (w.last_in_row)
        begin
            for (int k = 0; k < row_len; k++)
            begin
                r = round_half_up(row_prob[k] * (row_grad[k] - row_dot));
                if (r > 64'sd2147483647)
                    r = 64'sd2147483647;
                if (r < -64'sd2147483648)
                    r = -64'sd2147483648;
                o.grad_out     = r[31:0];
                o.last_out     = (k + 1 == row_len);
                o.row_overflow = row_dropped;
                expected_grads.push_back(o);
            end
            row_dot     = 0;
            row_len     = 0;
            row_dropped = 1'b0;
        end
    endfunction

    function automatic void check_result(input out_word_t got);
        out_word_t want;
        if (expected_grads.size() == 0)
        begin
            $error("unexpected result: grad_out %0d last_out %0b row_overflow %0b",
                   $signed(got.grad_out), got.last_out, got.row_overflow);
            fail_count++;
            return;
        end
        want = expected_grads.pop_front();
        if (got.grad_out !== want.grad_out)
        begin
            $error("grad_out: expected %0d, actual %0d",
                   $signed(want.grad_out), $signed(got.grad_out));
            fail_count++;
        end
        if (got.last_out !== want.last_out)
        begin
            $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
            fail_count++;
        end
        if (got.row_overflow !== want.row_overflow)
        begin
            $error("row_overflow: expected %0b, actual %0b",
                   want.row_overflow, got.row_overflow);
            fail_count++;
        end
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PROB_W-1:0] pick_prob();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return PROB_W'(65536);
        if (r < 30)
            return PROB_W'($urandom_range(65537, 131071));
        return PROB_W'($urandom_range(0, 65536));
    endfunction

    function automatic logic [GRAD_W-1:0] pick_grad();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom();
        if (r < 80)
            return GRAD_W'(int'($urandom_range(0, 2097152)) - 1048576);
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic void queue_element(input logic [PROB_W-1:0] p,
                                          input logic [GRAD_W-1:0] g, input logic last);
        in_word_t w;
        w.prob        = p;
        w.grad_in     = g;
        w.last_in_row = last;
        pending_words.push_back(w);
    endfunction

    function automatic int queue_random_row(input int len);
        for (int k = 0; k < len; k++)
            queue_element(pick_prob(), pick_grad(), k == len - 1);
        return len;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0)
            quiet <= ($urandom_range(0, 3) == 0);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_element(in_data);
                in_taken <= in_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_data  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    in_gap   <= pick_idle();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result(out_data);
            if (!pressure_done && in_taken >= 30)
            begin
                // hold off long enough for both row banks to fill
                pressure_done <= 1'b1;
                out_hold      <= 1500;
                out_ready     <= 1'b0;
            end
            else if (out_hold > 0)
            begin
                out_hold  <= out_hold - 1;
                out_ready <= 1'b0;
            end
            else if (quiet || $urandom_range(0, 99) < 65)
                out_ready <= 1'b1;
            else
            begin
                out_hold  <= pick_idle();
                out_ready <= 1'b0;
            end
        end
    end

    initial
    begin
        int made;
        int len;
        int r;

        queue_element(17'd65536, 32'h7FFF_FFFF, 1'b1);
        queue_element(17'd0, 32'h8000_0000, 1'b0);
        queue_element(17'd131071, 32'h7FFF_FFFF, 1'b0);
        queue_element(17'd65536, 32'h8000_0000, 1'b1);
        queue_element(17'd1, 32'h0000_0001, 1'b0);
        queue_element(17'd32768, 32'hFFFF_FFFF, 1'b0);
        queue_element(17'd65535, 32'h0000_8000, 1'b0);
        queue_element(17'd131071, 32'h8000_0000, 1'b1);
        queue_element(17'd16384, 32'h0001_0000, 1'b0);
        queue_element(17'd49152, 32'hFFFE_0000, 1'b0);
        queue_element(17'd65537, 32'h0000_4000, 1'b0);
        queue_element(17'd100000, 32'hFFFF_C000, 1'b1);
        queue_element(17'd0, 32'h0000_0000, 1'b1);
        queue_element(17'd131071, 32'hFFFF_FFFF, 1'b1);

        // full row, then one row past capacity whose elements beyond MAX_COLS are dropped
        made = queue_random_row(MAX_COLS);
        made += queue_random_row(MAX_COLS + 3);
        while (made < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                len = $urandom_range(1, 6);
            else if (r < 90)
                len = $urandom_range(7, 24);
            else if (r < 95)
                len = MAX_COLS;
            else
                len = $urandom_range(MAX_COLS + 1, MAX_COLS + 4);
            made += queue_random_row(len);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() > 0 || in_valid)
            @(posedge clk);
        while (expected_grads.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_grads.size() > 0)
            fail_count++;
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
